@@ rtl/stuffed_frame_receiver_defines.svh @@
// Assertion macros shared by the stuffed frame receiver RTL.
`ifndef STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define SFR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SFR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sfr_pkg.sv @@
// Types and constants of the stuffed frame receiver.
package sfr_pkg;

   localparam int MAX_FRAME_DEFAULT = 256;

   localparam logic [7:0] MARK_START = 8'hFE;
   localparam logic [7:0] MARK_END   = 8'hFF;

   typedef enum logic [2:0] {
      STAT_NONE     = 3'd0,
      STAT_START    = 3'd1,
      STAT_GOOD     = 3'd2,
      STAT_CSUM_ERR = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        byte_valid;
      logic [7:0]  byte_value;
      logic [7:0]  byte_index;
      logic [8:0]  frame_length;
   } result_type;

endpackage

@@ rtl/sfr_req_if.sv @@
// Request channel: one received byte per transaction.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sfr_rsp_if.sv @@
// Response channel: status and payload byte per transaction.
interface sfr_rsp_if
   import sfr_pkg::*;
   ;
   logic       valid;
   logic       ready;
   status_type status;
   logic       byte_valid;
   logic [7:0] byte_value;
   logic [7:0] byte_index;
   logic [8:0] frame_length;

   modport source (output valid, output status, output byte_valid, output byte_value,
                   output byte_index, output frame_length, input ready);
   modport sink   (input valid, input status, input byte_valid, input byte_value,
                   input byte_index, input frame_length, output ready);
endinterface

@@ rtl/sfr_in_stage.sv @@
// Input register of the stuffed frame receiver.
module sfr_in_stage (
   input  logic       clock,
   input  logic       reset,
   sfr_req_if.sink    req,
   input  logic       advance,
   output logic       hold_valid,
   output logic [7:0] hold_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // Refill whenever the held byte moves on or the stage is empty.
   assign req.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req.ready) begin
         valid_in = req.valid;
         if (req.valid) begin
            byte_in = req.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

@@ rtl/sfr_engine.sv @@
// Frame state and per-byte decode of the stuffed frame receiver.
`include "stuffed_frame_receiver_defines.svh"

module sfr_engine
   import sfr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output result_type result
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

   logic [15:0]      hist_ff, hist_in;
   logic             in_frame_ff, in_frame_in;
   logic [7:0]       xor_ff, xor_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   logic [15:0]      hist_new;
   logic [7:0]       prev;
   logic             after_mark;
   logic             keep;
   logic [7:0]       xor_end;
   logic [CNT_W+8:0] count_ext;
   logic [CNT_W+8:0] length_ext;
   logic [CNT_W-1:0] length_cnt;

   always_comb begin
      hist_new   = {hist_ff[7:0], rx_byte};
      prev       = hist_ff[7:0];
      after_mark = (prev == MARK_START) || (prev == MARK_END);
      xor_end    = xor_ff ^ MARK_END;
      count_ext  = {9'd0, count_ff};
      length_cnt = (count_ff >= CNT_TWO) ? count_ff - CNT_TWO : '0;
      length_ext = {9'd0, length_cnt};

      hist_in     = hist_new;
      in_frame_in = in_frame_ff;
      xor_in      = xor_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      keep        = 1'b0;
      result      = '{status: STAT_NONE, byte_valid: 1'b0, byte_value: 8'd0,
                      byte_index: 8'd0, frame_length: 9'd0};

      if (in_frame_ff) begin
         if (rx_byte == MARK_START) begin
            if (prev == MARK_START) begin
               // restart: drop everything gathered so far
               hist_in  = '0;
               xor_in   = '0;
               count_in = '0;
               ovf_in   = 1'b0;
            end else begin
               keep = 1'b1;
            end
         end else if (rx_byte == MARK_END) begin
            if (prev == MARK_END) begin
               in_frame_in = 1'b0;
               xor_in      = '0;
               ovf_in      = 1'b0;
               if (ovf_ff) begin
                  result.status = STAT_OVERFLOW;
                  count_in      = '0;
               end else if (xor_end == 8'd0) begin
                  result.status       = STAT_GOOD;
                  count_in            = length_cnt;
                  result.frame_length = length_ext[8:0];
               end else begin
                  result.status = STAT_CSUM_ERR;
                  count_in      = '0;
               end
            end else begin
               keep = 1'b1;
            end
         end else begin
            keep = !after_mark;
         end
      end else if (hist_new == {MARK_START, MARK_START}) begin
         hist_in       = '0;
         in_frame_in   = 1'b1;
         xor_in        = '0;
         count_in      = '0;
         ovf_in        = 1'b0;
         result.status = STAT_START;
      end

      if (keep) begin
         xor_in = xor_ff ^ rx_byte;
         if (count_ff >= CNT_MAX) begin
            ovf_in = 1'b1;
         end else begin
            result.byte_valid = 1'b1;
            result.byte_value = rx_byte;
            result.byte_index = count_ext[7:0];
            count_in          = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         in_frame_ff <= 1'b0;
         xor_ff      <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else if (step) begin
         hist_ff     <= hist_in;
         in_frame_ff <= in_frame_in;
         xor_ff      <= xor_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
      end
   end

   `SFR_ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= CNT_MAX, "count past capacity")
   `SFR_ASSERT_ALWAYS(a_ovf_in_frame, clock, reset, !ovf_ff || in_frame_ff, "overflow outside frame")
   `SFR_ASSERT_IMPLY(a_byte_no_status, clock, reset, step && result.byte_valid, result.status == STAT_NONE, "byte with status")
   `SFR_ASSERT_NEXT(a_start_enters, clock, reset, step && result.status == STAT_START, in_frame_ff && count_ff == '0, "start did not open frame")

endmodule

@@ rtl/stuffed_frame_receiver.sv @@
// Top level of the byte-stuffed frame receiver with XOR checksum.
//
//   channel | dir | transaction carries
//   --------+-----+--------------------------------------------------------
//   req     | in  | rx_byte: one received byte from the serial line
//   rsp     | out | status, byte_valid, byte_value, byte_index, frame_length
//
// One rsp transaction per req transaction, in order. A byte passes two registers:
// the input register, then through the decode into the result register.
// Throughput is one transaction per cycle while rsp does not stall; the update of
// the frame state (history, checksum, count) in each step sets that figure.
// Reset clears the frame state and both stage valid flags; payload is not reset.
// A stall on rsp holds the result register and backs up into req.ready.
`include "stuffed_frame_receiver_defines.svh"

module stuffed_frame_receiver
   import sfr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req,
   sfr_rsp_if.source rsp
);

   logic       hold_valid;
   logic [7:0] hold_byte;
   logic       advance;
   result_type step_result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // Advance the held byte when the result register is empty or being drained.
   assign advance = hold_valid && (!rsp_valid_ff || rsp.ready);

   sfr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   sfr_engine #(
      .MAX_FRAME (MAX_FRAME)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (hold_byte),
      .result  (step_result)
   );

   // Load on advance, drop valid once taken with nothing behind it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_data_ff.status;
   assign rsp.byte_valid   = rsp_data_ff.byte_valid;
   assign rsp.byte_value   = rsp_data_ff.byte_value;
   assign rsp.byte_index   = rsp_data_ff.byte_index;
   assign rsp.frame_length = rsp_data_ff.frame_length;

   `SFR_ASSERT_IMPLY(a_no_step_on_stall, clock, reset, rsp_valid_ff && !rsp.ready, !advance, "result overwritten")
   `SFR_ASSERT_NEXT(a_step_loads, clock, reset, advance, rsp_valid_ff, "step lost")
   `SFR_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && !rsp.ready, rsp_valid_ff && $stable(rsp_data_ff), "result changed while stalled")

endmodule
